FILE: design/rau_pkg.sv
// Shared types, constants and command codes of the rational arithmetic unit.
package rau_pkg;

   localparam int OPERAND_BITS_DEFAULT = 31;
   localparam int FIELD_BITS = 31;
   localparam int NUM_BITS = 63;
   localparam int DEN_BITS = 61;
   localparam int MAG_BITS = 62;

   localparam logic [2:0] CMD_ADD = 3'd0;
   localparam logic [2:0] CMD_SUB = 3'd1;
   localparam logic [2:0] CMD_MUL = 3'd2;
   localparam logic [2:0] CMD_EQ  = 3'd3;
   localparam logic [2:0] CMD_NE  = 3'd4;
   localparam logic [2:0] CMD_GT  = 3'd5;
   localparam logic [2:0] CMD_LT  = 3'd6;

   // Request word.
   typedef struct packed {
      logic [2:0]            cmd;
      logic [FIELD_BITS-1:0] left_num;
      logic [FIELD_BITS-1:0] left_den;
      logic [FIELD_BITS-1:0] right_num;
      logic [FIELD_BITS-1:0] right_den;
   } req_type;

   // Response word.
   typedef struct packed {
      logic [NUM_BITS-1:0] res_num;
      logic [DEN_BITS-1:0] res_den;
      logic                compare_true;
      logic                div_error;
   } rsp_type;

endpackage

FILE: design/rau_if.sv
// Valid/ready channel interfaces for request and response words.
interface rau_req_if;
   logic             valid;
   logic             ready;
   rau_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface rau_rsp_if;
   logic             valid;
   logic             ready;
   rau_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: design/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit.
// The block takes one request word (cmd and two signed fractions) on the req
// channel and returns one response word on the rsp channel. Every command
// cross-multiplies on one shared multiplier (states MUL0, MUL1, MUL2), then a
// binary gcd runs one shift or subtract per cycle, and two restoring
// divisions by the gcd follow. req_ready is low from accept until the
// response is ready. A zero denominator or a zero result skips the gcd and
// the divisions and goes from the sum straight to the output state.
// The response sits in an output register until taken; req_ready stays low
// while it waits, so a stalled receiver holds the block and the next request
// is accepted only once the response has been taken.
// Reset is synchronous and empties the block.
module rational_arithmetic_unit #(
   parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEFAULT
) (
   input logic clock,
   input logic reset,
   rau_req_if.sink   req,
   rau_rsp_if.source rsp
);
   logic busy_ff, busy_in, out_valid_ff, out_valid_in, done;
   rau_pkg::rsp_type core_rsp, out_ff, out_in;

   rau_core #(.OPERAND_BITS(OPERAND_BITS)) u_core (
      .clock(clock), .reset(reset), .start(req.valid && req.ready),
      .req(req.data), .done(done), .rsp(core_rsp));

   // Busy from accept until the result lands in the output register.
   always_comb begin
      busy_in = busy_ff;
      out_valid_in = out_valid_ff;
      out_in = out_ff;
      if (rsp.valid && rsp.ready) out_valid_in = 1'b0;
      if (req.valid && req.ready) busy_in = 1'b1;
      if (done) begin
         busy_in = 1'b0; out_valid_in = 1'b1; out_in = core_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; out_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign req.ready = !busy_ff && !out_valid_ff;
   assign rsp.valid = out_valid_ff;
   assign rsp.data = out_ff;
endmodule

FILE: design/rau_core.sv
// Sequenced datapath: one shared multiplier, then sum, gcd and divide.
module rau_core #(
   parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  rau_pkg::req_type req,
   output logic             done,
   output rau_pkg::rsp_type rsp
);
   localparam int M = rau_pkg::MAG_BITS;
   localparam int CW = $clog2(M + 1);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MUL0 = 4'd1;
   localparam logic [3:0] ST_MUL1 = 4'd2;
   localparam logic [3:0] ST_MUL2 = 4'd3;
   localparam logic [3:0] ST_SUM  = 4'd4;
   localparam logic [3:0] ST_GCDS = 4'd5;
   localparam logic [3:0] ST_GCD  = 4'd6;
   localparam logic [3:0] ST_DIVN = 4'd7;
   localparam logic [3:0] ST_DIVD = 4'd8;
   localparam logic [3:0] ST_OUT  = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [2:0] cmd_ff, cmd_in;
   logic signed [31:0] a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic signed [63:0] p0_ff, p1_ff, p0_in, p1_in;
   logic [M-1:0] mag_ff, den_ff, mag_in, den_in;
   logic neg_ff, neg_in, err_ff, err_in;
   logic [M-1:0] gx_ff, gy_ff, gx_in, gy_in;
   logic [CW-1:0] k_ff, k_in;
   logic [M-1:0] q_ff, r_ff, q_in, r_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   rau_pkg::rsp_type rsp_ff, rsp_in;

   // Sign extension of the low operand bits.
   function automatic logic signed [31:0] sext(input logic [rau_pkg::FIELD_BITS-1:0] raw);
      logic [OPERAND_BITS-1:0] v;
      v = raw[OPERAND_BITS-1:0];
      return 32'(signed'(v));
   endfunction

   // Shared multiplier operand selection.
   logic signed [31:0] mx, my;
   logic signed [63:0] prod;
   always_comb begin
      case (state_ff)
         ST_MUL0: begin mx = b_ff; my = d_ff; end
         ST_MUL1: begin mx = a_ff; my = (cmd_ff == rau_pkg::CMD_MUL) ? c_ff : d_ff; end
         default: begin mx = c_ff; my = b_ff; end
      endcase
      prod = mx * my;
   end

   logic [M-1:0] gdiff;
   logic [M:0] rsh;
   logic signed [63:0] nsum;
   logic [M-1:0] divisor;
   always_comb begin
      gdiff = (gx_ff > gy_ff) ? gx_ff - gy_ff : gy_ff - gx_ff;
      divisor = gx_ff << k_ff;
      rsh = {r_ff, q_ff[M-1]};
      nsum = (cmd_ff == rau_pkg::CMD_ADD) ? p0_ff + p1_ff : p0_ff - p1_ff;
   end

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      p0_in = p0_ff; p1_in = p1_ff; mag_in = mag_ff; den_in = den_ff;
      neg_in = neg_ff; err_in = err_ff; gx_in = gx_ff; gy_in = gy_ff;
      k_in = k_ff; q_in = q_ff; r_in = r_ff; cnt_in = cnt_ff; rsp_in = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in = req.cmd;
               a_in = sext(req.left_num); b_in = sext(req.left_den);
               c_in = sext(req.right_num); d_in = sext(req.right_den);
               if (sext(req.left_den) < 0) begin
                  a_in = -sext(req.left_num); b_in = -sext(req.left_den);
               end
               if (sext(req.right_den) < 0) begin
                  c_in = -sext(req.right_num); d_in = -sext(req.right_den);
               end
               err_in = (req.left_den[OPERAND_BITS-1:0] == '0) ||
                        (req.right_den[OPERAND_BITS-1:0] == '0);
               state_in = ST_MUL0;
            end
         end
         ST_MUL0: begin den_in = M'(prod); state_in = ST_MUL1; end
         ST_MUL1: begin p0_in = prod; state_in = ST_MUL2; end
         ST_MUL2: begin p1_in = (cmd_ff == rau_pkg::CMD_MUL) ? 64'sd0 : prod;
            state_in = ST_SUM; end
         ST_SUM: begin
            neg_in = nsum < 0;
            mag_in = M'(nsum < 0 ? -nsum : nsum);
            gx_in = M'(nsum < 0 ? -nsum : nsum);
            gy_in = den_ff; k_in = '0;
            state_in = (err_ff || nsum == 0) ? ST_OUT : ST_GCDS;
         end
         // Strip common factors of two, one per cycle.
         ST_GCDS: begin
            if (!gx_ff[0] && !gy_ff[0]) begin
               gx_in = gx_ff >> 1; gy_in = gy_ff >> 1; k_in = k_ff + 1'b1;
            end else state_in = ST_GCD;
         end
         // Binary gcd: remove a factor of two, or subtract, one step a cycle.
         ST_GCD: begin
            if (!gx_ff[0]) gx_in = gx_ff >> 1;
            else if (!gy_ff[0]) gy_in = gy_ff >> 1;
            else if (gx_ff == gy_ff) begin
               q_in = mag_ff; r_in = '0; cnt_in = '0; state_in = ST_DIVN;
            end else begin
               gx_in = (gx_ff < gy_ff) ? gx_ff : gy_ff;
               gy_in = gdiff;
            end
         end
         // Restoring division, one quotient bit a cycle; gx<<k is the gcd.
         ST_DIVN, ST_DIVD: begin
            if (rsh >= {1'b0, divisor}) begin
               r_in = M'(rsh - {1'b0, divisor}); q_in = {q_ff[M-2:0], 1'b1};
            end else begin
               r_in = rsh[M-1:0]; q_in = {q_ff[M-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(M - 1)) begin
               cnt_in = '0; r_in = '0;
               if (state_ff == ST_DIVN) begin
                  mag_in = q_in; q_in = den_ff; state_in = ST_DIVD;
               end else begin
                  den_in = q_in; state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (err_ff) rsp_in = '0;
            else begin
               rsp_in.res_num = neg_ff ? -(rau_pkg::NUM_BITS'(mag_ff))
                                       : rau_pkg::NUM_BITS'(mag_ff);
               rsp_in.res_den = (mag_ff == '0) ? rau_pkg::DEN_BITS'(1)
                                               : den_ff[rau_pkg::DEN_BITS-1:0];
               case (cmd_ff)
                  rau_pkg::CMD_EQ: rsp_in.compare_true = (mag_ff == '0);
                  rau_pkg::CMD_NE: rsp_in.compare_true = (mag_ff != '0);
                  rau_pkg::CMD_GT: rsp_in.compare_true = !neg_ff && mag_ff != '0;
                  rau_pkg::CMD_LT: rsp_in.compare_true = neg_ff;
                  default: rsp_in.compare_true = 1'b0;
               endcase
            end
            rsp_in.div_error = err_ff;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
      cmd_ff <= cmd_in; a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
      p0_ff <= p0_in; p1_ff <= p1_in; mag_ff <= mag_in; den_ff <= den_in;
      neg_ff <= neg_in; err_ff <= err_in; gx_ff <= gx_in; gy_ff <= gy_in;
      k_ff <= k_in; q_ff <= q_in; r_ff <= r_in; cnt_ff <= cnt_in; rsp_ff <= rsp_in;
   end

   assign done = (state_ff == ST_OUT);
   assign rsp = rsp_in;
endmodule
